>>> hw/rtl/usfs_pkg.sv
// shared types and constants of the utf-8 search fold stream
package usfs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_OUT     = 4;

    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [2:0]              cnt;
    } t_req;

endpackage

>>> hw/rtl/utf8_search_fold_stream_unit.sv
// top level of the utf-8 search fold stream: decoder, request queue, output serializer
//
// input side is a queue write port: i_in_byte is taken at a rising edge with push high
// and full low. result side is a queue read port: while empty is low the oldest result
// byte is on o_out_byte with o_run_last marking the last byte caused by one input byte;
// it is taken at a rising edge with pop high and empty low.
// the decoder takes one byte per cycle while full is low and writes the bytes it
// causes (zero to four) as one request into a queue of QUEUE_DEPTH entries; the
// serializer drains one byte per cycle while pop is high, so with pop held high
// plain text runs at one byte per cycle in and out. the first result byte of an input
// reaches the result ports through the queue and then the output register.
// an expansion to n bytes holds the output register until all n bytes are popped;
// the queue absorbs it and full rises only once QUEUE_DEPTH requests are waiting.
// bytes that only extend a sequence, and combining marks, write nothing.
// when pop stays low, results wait in the output register and the queue; nothing is lost.
// synchronous reset clears the sequence state, the queue and the output register;
// empty is high and full is low in the cycle after reset.
module utf8_search_fold_stream_unit #(
    parameter int QUEUE_DEPTH = usfs_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    usfs_pkg::t_req w_req;
    usfs_pkg::t_req w_head;
    logic           w_req_valid;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_q_rd;

    usfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_byte   (i_in_byte),
        .i_q_full    (w_q_full),
        .o_req_valid (w_req_valid),
        .o_req       (w_req)
    );

    usfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_req_valid),
        .i_data  (w_req),
        .i_rd    (w_q_rd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    usfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_head    (w_head),
        .i_pop     (pop),
        .o_q_rd    (w_q_rd),
        .o_empty   (empty),
        .o_byte    (o_out_byte),
        .o_last    (o_run_last)
    );

    assign full = w_q_full;

`ifndef ASSERT_OFF
    a_req_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_valid |-> (w_req.cnt != 3'd0) && (w_req.cnt <= 3'd4))
        else $error("request with bad byte count");

    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_req_valid)
        else $error("request written into a full queue");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_run_last) |=> !empty)
        else $error("result run cut short");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("output not empty after reset");
`endif

endmodule

>>> hw/rtl/usfs_front.sv
// front end: strict utf-8 decoder/folder, one byte per cycle unless the queue is full
module usfs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_in_byte,
    input  logic              i_q_full,
    output logic              o_req_valid,
    output usfs_pkg::t_req    o_req
);

    logic [7:0]  r_pend [3];
    logic [7:0]  n_pend [3];
    logic [1:0]  r_pcnt, n_pcnt;
    logic [2:0]  r_slen, n_slen;
    logic [20:0] r_cp, n_cp;

    logic        w_accept;
    logic        w_in_seq;
    logic        w_cont;
    logic [2:0]  w_rest3;
    logic [1:0]  w_rest;
    logic [20:0] w_cp_add;
    logic [20:0] w_cp_new;
    logic [20:0] w_thresh;
    logic        w_bad;
    logic [2:0]  w_len;
    logic [20:0] w_lead_cp;
    logic [3:0][7:0] w_raw;
    logic [1:0]  w_flush;
    logic [7:0]  w_bout;
    logic        w_emit;
    usfs_pkg::t_req w_req;

    // latin-1 u+00c0..u+00ff, upper byte zero means pass through
    function automatic logic [15:0] lat1(input logic [5:0] idx);
        logic [15:0] v;
        case (idx[4:0]) inside
            [5'd0:5'd5]:   v = {"a", 8'h00};
            5'd6:          v = "ae";
            5'd7:          v = {"c", 8'h00};
            [5'd8:5'd11]:  v = {"e", 8'h00};
            [5'd12:5'd15]: v = {"i", 8'h00};
            5'd16:         v = {"d", 8'h00};
            5'd17:         v = {"n", 8'h00};
            [5'd18:5'd22]: v = {"o", 8'h00};
            5'd23:         v = 16'h0000;
            5'd24:         v = {"o", 8'h00};
            [5'd25:5'd28]: v = {"u", 8'h00};
            5'd29:         v = {"y", 8'h00};
            5'd30:         v = "th";
            default:       v = idx[5] ? {"y", 8'h00} : "ss";
        endcase
        return v;
    endfunction

    // latin extended-a u+0100..u+017f base letters
    function automatic logic [7:0] latx(input logic [6:0] idx);
        logic [7:0] v;
        case (idx) inside
            [7'h00:7'h05]: v = "a";
            [7'h06:7'h0D]: v = "c";
            [7'h0E:7'h11]: v = "d";
            [7'h12:7'h1B]: v = "e";
            [7'h1C:7'h23]: v = "g";
            [7'h24:7'h27]: v = "h";
            [7'h28:7'h32]: v = "i";
            [7'h33:7'h35]: v = "j";
            [7'h36:7'h38]: v = "k";
            [7'h39:7'h42]: v = "l";
            [7'h43:7'h4B]: v = "n";
            [7'h4C:7'h52]: v = "o";
            7'h53:         v = "e";
            [7'h54:7'h59]: v = "r";
            [7'h5A:7'h61]: v = "s";
            [7'h62:7'h67]: v = "t";
            [7'h68:7'h73]: v = "u";
            [7'h74:7'h75]: v = "w";
            [7'h76:7'h78]: v = "y";
            [7'h79:7'h7E]: v = "z";
            default:       v = "s";
        endcase
        return v;
    endfunction

    function automatic usfs_pkg::t_req fold(input logic [20:0] cp,
                                            input logic [3:0][7:0] raw,
                                            input logic [2:0] rawlen);
        usfs_pkg::t_req r;
        logic [15:0]    l1;
        r.bytes = raw;
        r.cnt   = rawlen;
        l1      = lat1(cp[5:0]);
        if (cp inside {[21'h000300:21'h00036F]}) begin
            r.cnt = 3'd0;
        end else if (cp inside {[21'h0000C0:21'h0000FF]}) begin
            if (l1[15:8] != 8'h00) begin
                r.bytes[0] = l1[15:8];
                r.bytes[1] = l1[7:0];
                r.cnt      = (l1[7:0] != 8'h00) ? 3'd2 : 3'd1;
            end
        end else if (cp inside {[21'h000100:21'h00017F]}) begin
            if (cp inside {21'h000132, 21'h000133}) begin
                r.bytes[0] = "i";
                r.bytes[1] = "j";
                r.cnt      = 3'd2;
            end else if (cp inside {21'h000152, 21'h000153}) begin
                r.bytes[0] = "o";
                r.bytes[1] = "e";
                r.cnt      = 3'd2;
            end else begin
                r.bytes[0] = latx(cp[6:0]);
                r.cnt      = 3'd1;
            end
        end else if (cp inside {21'h0000AB, 21'h0000BB, [21'h00201C:21'h00201F]}) begin
            r.bytes[0] = "\"";
            r.cnt      = 3'd1;
        end else if (cp inside {[21'h002018:21'h00201B]}) begin
            r.bytes[0] = "'";
            r.cnt      = 3'd1;
        end else if (cp inside {[21'h002010:21'h002015]}) begin
            r.bytes[0] = "-";
            r.cnt      = 3'd1;
        end else if (cp == 21'h002026) begin
            r.bytes[0] = ".";
            r.bytes[1] = ".";
            r.bytes[2] = ".";
            r.cnt      = 3'd3;
        end else if (cp inside {21'h0000A0, 21'h00202F, 21'h00205F,
                                [21'h002000:21'h00200A]}) begin
            r.bytes[0] = " ";
            r.cnt      = 3'd1;
        end
        return r;
    endfunction

    assign w_accept = i_push && !i_q_full;
    assign w_in_seq = (r_slen >= 3'd2) && (r_slen <= 3'd4) && (r_pcnt != 2'd0)
                      && ({1'b0, r_pcnt} < r_slen);
    assign w_cont   = (i_in_byte[7:6] == 2'b10);
    assign w_rest3  = r_slen - {1'b0, r_pcnt} - 3'd1;
    assign w_rest   = w_rest3[1:0];

    always_comb begin
        case (w_rest)
            2'd0:    w_cp_add = {15'd0, i_in_byte[5:0]};
            2'd1:    w_cp_add = {9'd0, i_in_byte[5:0], 6'd0};
            2'd2:    w_cp_add = {3'd0, i_in_byte[5:0], 12'd0};
            default: w_cp_add = 21'd0;
        endcase
    end

    assign w_cp_new = r_cp | w_cp_add;
    assign w_thresh = (r_slen == 3'd4) ? 21'h010000 : 21'h000800;
    assign w_bad    = ((r_slen == 3'd4) && (r_pcnt == 2'd1) && (w_cp_new >= 21'h110000))
                   || ((r_slen >= 3'd3) && ({1'b0, r_pcnt} == r_slen - 3'd2)
                       && (((w_cp_new >= 21'h00D800) && (w_cp_new < 21'h00E000))
                           || (w_cp_new < w_thresh)));

    assign w_len     = (i_in_byte >= 8'hF0) ? 3'd4 : (i_in_byte >= 8'hE0) ? 3'd3 : 3'd2;
    assign w_lead_cp = (w_len == 3'd4) ? {i_in_byte[2:0], 18'd0}
                     : (w_len == 3'd3) ? {5'd0, i_in_byte[3:0], 12'd0}
                     : {10'd0, i_in_byte[4:0], 6'd0};

    assign w_raw[0] = r_pend[0];
    assign w_raw[1] = (r_pcnt > 2'd1) ? r_pend[1] : i_in_byte;
    assign w_raw[2] = (r_pcnt > 2'd2) ? r_pend[2] : i_in_byte;
    assign w_raw[3] = i_in_byte;

    always_comb begin
        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        n_slen  = r_slen;
        n_cp    = r_cp;
        w_req   = '0;
        w_flush = 2'd0;
        w_bout  = i_in_byte;
        w_emit  = 1'b0;
        if (w_in_seq && w_cont && !w_bad) begin
            if (w_rest == 2'd0) begin
                w_req  = fold(w_cp_new, w_raw, r_slen);
                n_pcnt = 2'd0;
                n_slen = 3'd0;
                n_cp   = 21'd0;
            end else begin
                n_pend[r_pcnt] = i_in_byte;
                n_pcnt         = r_pcnt + 2'd1;
                n_cp           = w_cp_new;
            end
        end else begin
            w_flush = w_in_seq ? r_pcnt : 2'd0;
            n_pcnt  = 2'd0;
            n_slen  = 3'd0;
            n_cp    = 21'd0;
            if (i_in_byte < 8'h80) begin
                w_emit = 1'b1;
                if (i_in_byte inside {["A":"Z"]}) begin
                    w_bout = i_in_byte + 8'h20;
                end
            end else if ((i_in_byte < 8'hC2) || (i_in_byte > 8'hF4)) begin
                w_emit = 1'b1;
            end else begin
                n_pend[0] = i_in_byte;
                n_pcnt    = 2'd1;
                n_slen    = w_len;
                n_cp      = w_lead_cp;
            end
            w_req.bytes[0] = (w_flush > 2'd0) ? r_pend[0] : w_bout;
            w_req.bytes[1] = (w_flush > 2'd1) ? r_pend[1] : w_bout;
            w_req.bytes[2] = (w_flush > 2'd2) ? r_pend[2] : w_bout;
            w_req.bytes[3] = w_bout;
            w_req.cnt      = {1'b0, w_flush} + {2'b00, w_emit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 2'd0;
            r_slen <= 3'd0;
            r_cp   <= 21'd0;
        end else if (w_accept) begin
            r_pcnt <= n_pcnt;
            r_slen <= n_slen;
            r_cp   <= n_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend <= n_pend;
        end
    end

    assign o_req_valid = w_accept && (w_req.cnt != 3'd0);
    assign o_req       = w_req;

endmodule

>>> hw/rtl/usfs_queue.sv
// request queue between the decoder and the output serializer
module usfs_queue #(
    parameter int DEPTH = usfs_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  usfs_pkg::t_req i_data,
    input  logic           i_rd,
    output logic           o_full,
    output logic           o_empty,
    output usfs_pkg::t_req o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    usfs_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

endmodule

>>> hw/rtl/usfs_back.sv
// back end: output register that sends each request out one byte at a time
module usfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  usfs_pkg::t_req i_head,
    input  logic           i_pop,
    output logic           o_q_rd,
    output logic           o_empty,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    usfs_pkg::t_req r_req;
    logic [1:0]     r_idx;
    logic           r_valid;
    logic           w_take;
    logic           w_load;

    assign o_last = ({1'b0, r_idx} == r_req.cnt - 3'd1);
    assign w_take = r_valid && i_pop;
    assign w_load = !r_valid || (w_take && o_last);
    assign o_q_rd = w_load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= !i_q_empty;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_req <= i_head;
        end
    end

    assign o_empty = !r_valid;
    assign o_byte  = r_req.bytes[r_idx];

endmodule
